// File: design/rdcw_pkg.sv
// ----------------------------------------------------------------------------
// rdcw_pkg: shared types and codes for the range distinct count block
// Field widths of the input and result beats and the request codes.
// ----------------------------------------------------------------------------
package rdcw_pkg;

  localparam int REQ_W   = 2;
  localparam int ELEM_W  = 12;
  localparam int POS_W   = 13;
  localparam int COUNT_W = 13;

  typedef logic [REQ_W-1:0]   req_t;
  typedef logic [ELEM_W-1:0]  elem_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam req_t REQ_LOAD    = 2'd0;
  localparam req_t REQ_QUERY   = 2'd1;
  localparam req_t REQ_RESTART = 2'd2;

endpackage

// File: design/range_distinct_count_window_core.sv
// ----------------------------------------------------------------------------
// range_distinct_count_window_core: distinct values in a range of a loaded array
// Keeps a value histogram over a sliding window and walks the window one
// element at a time to each queried range.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one request per beat:
// a load appends elem_value to the array, a query asks for the number of
// distinct values in positions range_left..range_right (1-based), and a
// restart empties the array, the window and the histogram. Only queries give
// a result beat on the output channel (out_valid/out_ready); a query with
// left of zero, left above right or right beyond the loaded length answers
// bad_query with a count of zero and leaves the window alone.
// Timing: on a load, the quotient by the value range comes from a reciprocal
// multiplication as the beat is taken, and the remainder is stored in the
// next cycle. A query takes each element that enters or leaves the window
// through these steps in order: read the element store, read the count and
// write the count back. Its cost is thus set by how far the window moves
// from the previous query. A restart, and the clearing pass after reset,
// clear the histogram one entry per cycle; no request is taken during that
// pass.
// The block works on one request at a time. A finished result sits in the
// output register, so the next request is taken while the receiver stalls;
// a later result waits until that register has been taken.
// ----------------------------------------------------------------------------
module range_distinct_count_window_core #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int VALUE_RANGE  = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rdcw_pkg::req_t  req_type,
  input  rdcw_pkg::elem_t elem_value,
  input  rdcw_pkg::pos_t  range_left,
  input  rdcw_pkg::pos_t  range_right,
  output logic            out_valid,
  input  logic            out_ready,
  output rdcw_pkg::count_t distinct_count,
  output logic            bad_query
);

  import rdcw_pkg::*;

  // Element store address, position, histogram count and value widths.
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int PW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int VW = $clog2(VALUE_RANGE);
  localparam int WW0 = (PW > POS_W) ? PW : POS_W;
  localparam int WW  = (WW0 > COUNT_W) ? WW0 : COUNT_W;

  // The quotient by the value range is the top of a product with a rounded-up
  // reciprocal; with this shift it is exact for every value of the field.
  localparam int            RED_SH  = ELEM_W + VW;
  localparam longint        RED_MUL = ((longint'(1) << RED_SH) + VALUE_RANGE - 1) /
                                      VALUE_RANGE;
  localparam logic [ELEM_W:0]   RED_M = (ELEM_W + 1)'(RED_MUL);
  localparam logic [ELEM_W-1:0] RED_R = ELEM_W'(VALUE_RANGE);

  localparam logic [VW-1:0]  CLR_LAST  = VW'(VALUE_RANGE - 1);
  localparam logic [PW-1:0]  MAX_C     = PW'(MAX_ELEMENTS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_RDCNT = 3'd4;
  localparam logic [2:0] ST_WRCNT = 3'd5;
  localparam logic [2:0] ST_REPLY = 3'd6;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [PW-1:0]  length;
  logic [PW-1:0]  win_low;
  logic [PW-1:0]  win_high;
  logic [CW-1:0]  total;
  logic [PW-1:0]  q_left;
  logic [PW-1:0]  q_right;
  logic           step_add;
  logic [VW-1:0]  cnt_addr;
  logic [VW-1:0]  clr_addr;
  elem_t          ld_value;
  elem_t          ld_quot;
  count_t         res_count;
  logic           res_bad;

  // Memory ports.
  logic           elem_we;
  logic [AW-1:0]  elem_waddr;
  logic [AW-1:0]  elem_raddr;
  logic [VW-1:0]  elem_rdata;
  logic           cnt_we;
  logic [VW-1:0]  cnt_waddr;
  logic [CW-1:0]  cnt_wdata;
  logic [CW-1:0]  cnt_rdata;

  // Walk decision.
  logic [PW-1:0]  walk_pos;
  logic           walk_add;
  logic           walk_done;
  logic [PW-1:0]  low_next;
  logic [PW-1:0]  high_next;

  // Count update.
  logic [CW-1:0]  cnt_new;
  logic [CW-1:0]  total_next;

  // Value reduction and query check.
  logic [2*ELEM_W:0] red_prod;
  logic [VW-1:0]  ld_rem;
  logic           accept;
  logic           query_bad;

  rdcw_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (ld_rem),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  rdcw_ram #(.WIDTH(CW), .DEPTH(VALUE_RANGE)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (elem_rdata),
    .rdata (cnt_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign query_bad = (range_left == '0) ||
                     (WW'(range_left) > WW'(range_right)) ||
                     (WW'(range_right) > WW'(length));

  assign red_prod = (2*ELEM_W + 1)'(elem_value) * (2*ELEM_W + 1)'(RED_M);
  assign ld_rem   = VW'(ld_value - ELEM_W'(ld_quot * RED_R));

  assign elem_we    = (state == ST_LOAD);
  assign elem_waddr = length[AW-1:0];

  // The window grows first and shrinks afterwards, so no count goes negative.
  always_comb begin
    walk_pos  = win_low;
    walk_add  = 1'b0;
    walk_done = 1'b0;
    low_next  = win_low;
    high_next = win_high;
    if (win_low > q_left) begin
      walk_pos = win_low - 1'b1;
      walk_add = 1'b1;
      low_next = win_low - 1'b1;
    end else if (win_high < q_right) begin
      walk_pos  = win_high + 1'b1;
      walk_add  = 1'b1;
      high_next = win_high + 1'b1;
    end else if (win_low < q_left) begin
      walk_pos = win_low;
      low_next = win_low + 1'b1;
    end else if (win_high > q_right) begin
      walk_pos  = win_high;
      high_next = win_high - 1'b1;
    end else begin
      walk_done = 1'b1;
    end
  end

  assign elem_raddr = AW'(walk_pos - 1'b1);

  always_comb begin
    cnt_new    = cnt_rdata;
    total_next = total;
    if (step_add) begin
      cnt_new = cnt_rdata + 1'b1;
      if (cnt_rdata == '0) begin
        total_next = total + 1'b1;
      end
    end else if (cnt_rdata != '0) begin
      cnt_new = cnt_rdata - 1'b1;
      if (cnt_rdata == CW'(1)) begin
        total_next = total - 1'b1;
      end
    end
  end

  assign cnt_we    = (state == ST_CLEAR) || (state == ST_WRCNT);
  assign cnt_waddr = (state == ST_CLEAR) ? clr_addr : cnt_addr;
  assign cnt_wdata = (state == ST_CLEAR) ? '0 : cnt_new;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_LOAD: begin
              if (length < MAX_C) begin
                state_next = ST_LOAD;
              end
            end
            REQ_QUERY:   state_next = query_bad ? ST_REPLY : ST_WALK;
            REQ_RESTART: state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_WALK:  state_next = walk_done ? ST_REPLY : ST_RDCNT;
      ST_RDCNT: state_next = ST_WRCNT;
      ST_WRCNT: state_next = ST_WALK;
      ST_REPLY: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      length    <= '0;
      win_low   <= PW'(1);
      win_high  <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && (state != ST_REPLY)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          ld_value  <= elem_value;
          ld_quot   <= ELEM_W'(red_prod >> RED_SH);
          clr_addr  <= '0;
          q_left    <= PW'(range_left);
          q_right   <= PW'(range_right);
          res_count <= '0;
          res_bad   <= 1'b1;
          if (accept && (req_type == REQ_RESTART)) begin
            length   <= '0;
            win_low  <= PW'(1);
            win_high <= '0;
            total    <= '0;
          end
        end
        ST_LOAD: begin
          length <= length + 1'b1;
        end
        ST_WALK: begin
          win_low  <= low_next;
          win_high <= high_next;
          step_add <= walk_add;
          if (walk_done) begin
            res_count <= COUNT_W'(WW'(total));
            res_bad   <= 1'b0;
          end
        end
        ST_RDCNT: begin
          cnt_addr <= elem_rdata;
        end
        ST_WRCNT: begin
          total <= total_next;
        end
        ST_REPLY: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            distinct_count <= res_count;
            bad_query      <= res_bad;
          end
        end
        default: begin
          clr_addr <= '0;
        end
      endcase
    end
  end

endmodule

// File: design/rdcw_ram.sv
// ----------------------------------------------------------------------------
// rdcw_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rdcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: verif/range_distinct_count_window_core_test.sv
// ----------------------------------------------------------------------------
// range_distinct_count_window_core_test: self-checking bench for the core
// Sends loads, range queries, restarts and unused request codes with random
// gaps on the request side and random stalls on the result side. A behavioral
// copy of the value histogram and window predicts each answer not typed in. Each result
// beat is compared in order against the oldest pending answer.
// ----------------------------------------------------------------------------
module range_distinct_count_window_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcw_pkg::*;

  localparam int   ARRAY_DEPTH   = 4096;
  localparam int   VALUE_SPAN    = 4096;
  localparam int   LONG_ARRAY    = 256;
  localparam int   RANDOM_ITEMS  = 860;
  localparam int   TAIL_ITEMS    = 100;
  localparam int   CYCLE_LIMIT   = 10_000_000;
  localparam int   SETTLE_CYCLES = 4200;
  localparam int   MAX_REPORTS   = 10;
  localparam req_t REQ_UNUSED    = 2'd3;

  typedef struct packed {
    count_t count;
    logic   bad;
  } answer_t;

  typedef struct packed {
    req_t   rq;
    elem_t  ev;
    pos_t   rl;
    pos_t   rr;
    logic   typed;
    count_t count;
    logic   bad;
  } stim_row_t;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   in_valid    = 1'b0;
  logic   in_ready;
  req_t   req_type    = REQ_LOAD;
  elem_t  elem_value  = '0;
  pos_t   range_left  = '0;
  pos_t   range_right = '0;
  logic   out_valid;
  logic   out_ready   = 1'b0;
  count_t distinct_count;
  logic   bad_query;

  // Predicted state of the block.
  elem_t   loaded_values [ARRAY_DEPTH];
  count_t  value_hist [VALUE_SPAN];
  pos_t    loaded_len;
  pos_t    win_low;
  pos_t    win_high;
  count_t  distinct_now;
  answer_t pending_answers [$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_left    = 0;
  logic quiet_tail    = 1'b0;
  int   mismatches    = 0;
  int   n_loads       = 0;
  int   n_queries     = 0;
  int   n_rejected    = 0;
  int   n_restarts    = 0;
  int   n_unknown     = 0;
  int   n_answers     = 0;
  int   longest       = 0;
  count_t top_count   = '0;

  // Expected answers of the directed rows are typed in where they are obvious.
  // Array after the six loads: 0, 4095, 4095, 0xAAA, 0x555, 0.
  stim_row_t directed_rows [22] = '{
    '{REQ_QUERY,   12'd0,     13'd1,    13'd1,    1'b1, 13'd0, 1'b1},
    '{REQ_LOAD,    12'd0,     13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_LOAD,    12'd4095,  13'd8191, 13'd8191, 1'b0, 13'd0, 1'b0},
    '{REQ_LOAD,    12'd4095,  13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_LOAD,    12'hAAA,   13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_LOAD,    12'h555,   13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_LOAD,    12'd0,     13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd0,    13'd3,    1'b1, 13'd0, 1'b1},
    '{REQ_QUERY,   12'd0,     13'd3,    13'd2,    1'b1, 13'd0, 1'b1},
    '{REQ_QUERY,   12'd0,     13'd1,    13'd7,    1'b1, 13'd0, 1'b1},
    '{REQ_QUERY,   12'd4095,  13'd8191, 13'd8191, 1'b1, 13'd0, 1'b1},
    '{REQ_QUERY,   12'd0,     13'd4096, 13'd4096, 1'b1, 13'd0, 1'b1},
    '{REQ_QUERY,   12'd0,     13'd1,    13'd1,    1'b1, 13'd1, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd1,    13'd6,    1'b1, 13'd4, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd2,    13'd3,    1'b1, 13'd1, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd6,    13'd6,    1'b1, 13'd1, 1'b0},
    '{REQ_UNUSED,  12'h5A5,   13'h1555, 13'h0AAA, 1'b0, 13'd0, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd3,    13'd5,    1'b0, 13'd0, 1'b0},
    '{REQ_RESTART, 12'hFFF,   13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd1,    13'd1,    1'b1, 13'd0, 1'b1},
    '{REQ_LOAD,    12'd7,     13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
    '{REQ_QUERY,   12'd0,     13'd1,    13'd1,    1'b1, 13'd1, 1'b0}
  };

  range_distinct_count_window_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .elem_value     (elem_value),
    .range_left     (range_left),
    .range_right    (range_right),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distinct_count (distinct_count),
    .bad_query      (bad_query)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_window();
    foreach (value_hist[i]) value_hist[i] = '0;
    loaded_len   = '0;
    win_low      = 13'd1;
    win_high     = '0;
    distinct_now = '0;
  endfunction

  function automatic void hist_add(pos_t pos);
    elem_t v;
    v = loaded_values[pos - 1'b1];
    if (value_hist[v] == 0) distinct_now = distinct_now + 1'b1;
    value_hist[v] = value_hist[v] + 1'b1;
  endfunction

  function automatic void hist_drop(pos_t pos);
    elem_t v;
    v = loaded_values[pos - 1'b1];
    if (value_hist[v] != 0) begin
      value_hist[v] = value_hist[v] - 1'b1;
      if (value_hist[v] == 0) distinct_now = distinct_now - 1'b1;
    end
  endfunction

  // Applies one accepted request to the predicted state.
  task automatic apply_request(input req_t rq, input elem_t ev, input pos_t rl,
                               input pos_t rr, output logic gives, output answer_t ans);
    gives = 1'b0;
    ans   = '0;
    case (rq)
      REQ_LOAD: begin
        n_loads++;
        // A full store drops the value silently.
        if (loaded_len < ARRAY_DEPTH) begin
          loaded_values[loaded_len] = elem_t'(ev % VALUE_SPAN);
          loaded_len = loaded_len + 1'b1;
          if (loaded_len > longest) longest = int'(loaded_len);
        end
      end
      REQ_RESTART: begin
        n_restarts++;
        clear_window();
      end
      REQ_QUERY: begin
        n_queries++;
        gives = 1'b1;
        if (rl == 0 || rl > rr || rr > loaded_len) begin
          n_rejected++;
          ans.bad = 1'b1;
        end else begin
          // Grow first, then shrink, so no count ever goes below zero.
          while (win_low > rl) begin
            win_low = win_low - 1'b1;
            hist_add(win_low);
          end
          while (win_high < rr) begin
            win_high = win_high + 1'b1;
            hist_add(win_high);
          end
          while (win_low < rl) begin
            hist_drop(win_low);
            win_low = win_low + 1'b1;
          end
          while (win_high > rr) begin
            hist_drop(win_high);
            win_high = win_high - 1'b1;
          end
          ans.count = distinct_now;
          if (distinct_now > top_count) top_count = distinct_now;
        end
      end
      default: begin
        n_unknown++;
      end
    endcase
  endtask

  task automatic send_request(input req_t rq, input elem_t ev, input pos_t rl,
                              input pos_t rr, input logic typed, input count_t want_count,
                              input logic want_bad);
    logic    gives;
    answer_t ans;
    answer_t typed_ans;
    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    elem_value  <= ev;
    range_left  <= rl;
    range_right <= rr;
    do @(posedge clk); while (!in_ready);
    apply_request(rq, ev, rl, rr, gives, ans);
    typed_ans.count = want_count;
    typed_ans.bad   = want_bad;
    if (gives) pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  task automatic send_item(input req_t rq, input elem_t ev, input pos_t rl, input pos_t rr);
    send_request(rq, ev, rl, rr, 1'b0, '0, 1'b0);
  endtask

  // Holds the request side low until every pending answer has come back.
  task automatic wait_all_answered();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed ranges over the loaded array, the rest rejected shapes.
  task automatic send_random_query();
    pos_t l;
    pos_t r;
    case ($urandom_range(0, 9))
      0: begin
        l = '0;
        r = pos_t'($urandom_range(0, 8191));
      end
      1: begin
        l = pos_t'($urandom_range(2, 8191));
        r = pos_t'($urandom_range(1, l - 1));
      end
      2: begin
        r = pos_t'($urandom_range(loaded_len + 1, 8191));
        l = pos_t'($urandom_range(1, r));
      end
      3: begin
        l = pos_t'($urandom);
        r = pos_t'($urandom);
      end
      default: begin
        if (loaded_len == 0) begin
          l = 13'd1;
          r = 13'd1;
        end else begin
          l = pos_t'($urandom_range(1, loaded_len));
          r = pos_t'($urandom_range(l, loaded_len));
        end
      end
    endcase
    send_item(REQ_QUERY, elem_t'($urandom), l, r);
  endtask

  // Narrow alphabets give many repeated values, the wide one mostly distinct.
  function automatic elem_t pick_value(int mode);
    case (mode)
      0:       return elem_t'($urandom_range(0, 3));
      1:       return elem_t'($urandom_range(0, 31));
      2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : answer_check
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      n_answers++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no query pending: count %0d bad %0b",
                                  n_answers, distinct_count, bad_query));
      end else begin
        want = pending_answers.pop_front();
        if (distinct_count !== want.count)
          report_mismatch($sformatf("beat %0d distinct_count: expected %0d, got %0d",
                                    n_answers, want.count, distinct_count));
        if (bad_query !== want.bad)
          report_mismatch($sformatf("beat %0d bad_query: expected %0b, got %0b",
                                    n_answers, want.bad, bad_query));
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d answers outstanding.", pending_answers.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int random_items;
    int mode;
    int n_load;
    int n_ask;
    int pick;
    random_items = 0;
    clear_window();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 30;
    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].ev, directed_rows[i].rl,
                   directed_rows[i].rr, directed_rows[i].typed, directed_rows[i].count,
                   directed_rows[i].bad);
    wait_all_answered();

    // Build a longer array, then query the full span, the far end and one
    // position past it, then the upper half, the full span again and two random ones.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_item(REQ_RESTART, '0, '0, '0);
    repeat (LONG_ARRAY) send_item(REQ_LOAD, elem_t'($urandom), '0, '0);
    send_item(REQ_QUERY, '0, 13'd1, 13'd256);
    send_item(REQ_QUERY, '0, 13'd256, 13'd256);
    send_item(REQ_QUERY, '0, 13'd1, 13'd257);
    send_item(REQ_QUERY, '0, 13'd128, 13'd256);
    send_item(REQ_QUERY, '0, 13'd1, 13'd256);
    send_random_query();
    send_random_query();
    wait_all_answered();
    send_item(REQ_RESTART, '0, '0, '0);

    // Random sessions: optional restart, a run of loads, then queries mixed
    // with a few appended loads and unused request codes.
    while (random_items < RANDOM_ITEMS) begin
      quiet_tail    = (random_items >= RANDOM_ITEMS - TAIL_ITEMS);
      send_idle_pct = pick_idle_pct();
      recv_idle_pct = pick_idle_pct();
      if (loaded_len > 40 || $urandom_range(0, 2) == 0) begin
        send_item(REQ_RESTART, elem_t'($urandom), pos_t'($urandom), pos_t'($urandom));
        random_items++;
      end
      mode   = $urandom_range(0, 3);
      n_load = $urandom_range(1, 16);
      repeat (n_load) begin
        send_item(REQ_LOAD, pick_value(mode), pos_t'($urandom), pos_t'($urandom));
        random_items++;
      end
      n_ask = $urandom_range(4, 24);
      repeat (n_ask) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_item(REQ_UNUSED, elem_t'($urandom), pos_t'($urandom), pos_t'($urandom));
        end else if (pick == 1) begin
          send_item(REQ_LOAD, pick_value(mode), pos_t'($urandom), pos_t'($urandom));
          random_items++;
        end else begin
          send_random_query();
          random_items++;
        end
      end
      if ($urandom_range(0, 5) == 0) wait_all_answered();
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d loads (array up to %0d entries), %0d queries (%0d rejected),",
             n_loads, longest, n_queries, n_rejected);
    $display("%0d restarts and %0d unused codes; %0d answers compared, top count %0d.",
             n_restarts, n_unknown, n_answers, top_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
